>>> src/ubds_pkg.sv
// ubds_pkg: widths, limits and shared types for the baud divisor search
// no dependencies; used by ubds_div and uart_baud_divisor_search
package ubds_pkg;

  localparam int unsigned CLK_W  = 28;   // clock frequency and quotient width
  localparam int unsigned DVS_W  = 22;   // divisor width, covers 32 * 115200
  localparam int unsigned RATE_W = 17;   // clamped rate width
  localparam int unsigned OSR_W  = 6;
  localparam int unsigned DIV_W  = 14;
  localparam int unsigned DEV_W  = 32;
  localparam int unsigned CNT_W  = 5;    // holds CLK_W

  localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(115200);
  localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(1200);
  localparam logic [CLK_W-1:0]  DIV_LIMIT  = CLK_W'(8192);
  localparam logic [OSR_W-1:0]  OSR_TOP    = OSR_W'(32);
  localparam logic [OSR_W-1:0]  OSR_BOTTOM = OSR_W'(4);
  localparam logic [DEV_W-1:0]  DEV_START  = 32'hFFFF_FFFF;
  localparam logic [CLK_W-1:0]  CLOCK_RESET = CLK_W'(20971520);

  // request into the shared divider
  typedef struct packed {
    logic             start;
    logic [CLK_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  // result from the shared divider
  typedef struct packed {
    logic             done;
    logic [CLK_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> src/uart_baud_divisor_search.sv
// uart_baud_divisor_search: best oversampling ratio and baud divisor for a rate
// depends on ubds_pkg and ubds_div
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  cfg     | cfg_valid, cfg_ready, cfg_clock_hz[27:0]  | in
//  in      | in_valid, in_ready, in_requested_baud     | in
//  out     | out_valid, out_ready, out_oversample_ratio,| out
//          | out_baud_divisor                          |
//
// each request walks osr 32 down to 4, one division at a time on the one serial
// divider. a ratio whose base quotient is out of range is skipped, else it takes
// three divisions and a compare; an exact match ends the walk early. in_ready is
// high only while the sequencer is idle.
// synchronous active-low reset; clock_hz resets to 20971520, cfg always ready.
// a result waiting on out_ready holds the sequencer before the output register.
module uart_baud_divisor_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [27:0] cfg_clock_hz,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_requested_baud,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_oversample_ratio,
  output logic [13:0] out_baud_divisor
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_BASE  = 10'b00_0000_0010,
    S_WBASE = 10'b00_0000_0100,
    S_R1    = 10'b00_0000_1000,
    S_WR1   = 10'b00_0001_0000,
    S_R2    = 10'b00_0010_0000,
    S_WR2   = 10'b00_0100_0000,
    S_CMP   = 10'b00_1000_0000,
    S_NEXT  = 10'b01_0000_0000,
    S_OUT   = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [ubds_pkg::CLK_W-1:0]  clock_hz_r;
  logic [ubds_pkg::RATE_W-1:0] rate_r, rate_nxt;
  logic [ubds_pkg::OSR_W-1:0]  osr_r, osr_nxt;
  logic [12:0]                 d_r, d_nxt;
  logic [ubds_pkg::CLK_W-1:0]  r1_r, r1_nxt;
  logic [ubds_pkg::CLK_W-1:0]  r2_r, r2_nxt;
  logic [ubds_pkg::OSR_W-1:0]  best_osr_r, best_osr_nxt;
  logic [ubds_pkg::DIV_W-1:0]  best_div_r, best_div_nxt;
  logic [ubds_pkg::DEV_W-1:0]  best_dev_r, best_dev_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [ubds_pkg::OSR_W-1:0]  out_osr_r, out_osr_nxt;
  logic [ubds_pkg::DIV_W-1:0]  out_div_r, out_div_nxt;

  ubds_pkg::div_req_t div_req;
  ubds_pkg::div_rsp_t div_rsp;

  logic [ubds_pkg::RATE_W-1:0] rate_clamp;
  logic [ubds_pkg::DEV_W-1:0]  dev1, dev2, cand_dev;
  logic [ubds_pkg::DIV_W-1:0]  d_plus1, cand_div;
  logic [ubds_pkg::DVS_W-1:0]  base_prod;
  logic [18:0]                 r1_prod;
  logic [19:0]                 r2_prod;

  ubds_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    if (in_requested_baud > 32'(ubds_pkg::RATE_MAX)) begin
      rate_clamp = ubds_pkg::RATE_MAX;
    end else if (in_requested_baud < 32'(ubds_pkg::RATE_MIN)) begin
      rate_clamp = ubds_pkg::RATE_MIN;
    end else begin
      rate_clamp = in_requested_baud[ubds_pkg::RATE_W-1:0];
    end
  end

  assign d_plus1   = {1'b0, d_r} + 1'b1;
  assign base_prod = ubds_pkg::DVS_W'(osr_r) * ubds_pkg::DVS_W'(rate_r);
  assign r1_prod   = 19'(osr_r) * 19'(d_r);
  assign r2_prod   = 20'(osr_r) * 20'(d_plus1);

  // wrapping 32-bit deviations, as the divisor register would see them
  assign dev1 = 32'(r1_r) - 32'(rate_r);
  assign dev2 = 32'(rate_r) - 32'(r2_r);

  always_comb begin
    if (dev1 < dev2) begin
      cand_dev = dev1;
      cand_div = {1'b0, d_r};
    end else begin
      cand_dev = dev2;
      cand_div = d_plus1;
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = clock_hz_r;
    div_req.divisor  = base_prod;
    unique case (state_r)
      S_BASE: begin
        div_req.start   = 1'b1;
        div_req.divisor = base_prod;
      end
      S_R1: begin
        div_req.start   = 1'b1;
        div_req.divisor = ubds_pkg::DVS_W'(r1_prod);
      end
      S_R2: begin
        div_req.start   = 1'b1;
        div_req.divisor = ubds_pkg::DVS_W'(r2_prod);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    rate_nxt      = rate_r;
    osr_nxt       = osr_r;
    d_nxt         = d_r;
    r1_nxt        = r1_r;
    r2_nxt        = r2_r;
    best_osr_nxt  = best_osr_r;
    best_div_nxt  = best_div_r;
    best_dev_nxt  = best_dev_r;
    out_valid_nxt = out_valid_r;
    out_osr_nxt   = out_osr_r;
    out_div_nxt   = out_div_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          rate_nxt     = rate_clamp;
          osr_nxt      = ubds_pkg::OSR_TOP;
          best_osr_nxt = ubds_pkg::OSR_BOTTOM;
          best_div_nxt = ubds_pkg::DIV_W'(1);
          best_dev_nxt = ubds_pkg::DEV_START;
          state_nxt    = S_BASE;
        end
      end
      S_BASE: state_nxt = S_WBASE;
      S_WBASE: begin
        if (div_rsp.done) begin
          if (div_rsp.quotient >= ubds_pkg::DIV_LIMIT) begin
            state_nxt = S_NEXT;
          end else begin
            if (div_rsp.quotient == '0) begin
              d_nxt = 13'd1;
            end else begin
              d_nxt = div_rsp.quotient[12:0];
            end
            state_nxt = S_R1;
          end
        end
      end
      S_R1: state_nxt = S_WR1;
      S_WR1: begin
        if (div_rsp.done) begin
          r1_nxt    = div_rsp.quotient;
          state_nxt = S_R2;
        end
      end
      S_R2: state_nxt = S_WR2;
      S_WR2: begin
        if (div_rsp.done) begin
          r2_nxt    = div_rsp.quotient;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        state_nxt = S_NEXT;
        if (cand_dev < best_dev_r) begin
          best_osr_nxt = osr_r;
          best_div_nxt = cand_div;
          best_dev_nxt = cand_dev;
          // exact match ends the walk
          if (cand_dev == '0) begin
            state_nxt = S_OUT;
          end
        end
      end
      S_NEXT: begin
        if (osr_r == ubds_pkg::OSR_BOTTOM) begin
          state_nxt = S_OUT;
        end else begin
          osr_nxt   = osr_r - 1'b1;
          state_nxt = S_BASE;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_osr_nxt   = best_osr_r;
          out_div_nxt   = best_div_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      clock_hz_r  <= ubds_pkg::CLOCK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        clock_hz_r <= cfg_clock_hz;
      end
    end
  end

  always_ff @(posedge clk) begin
    rate_r     <= rate_nxt;
    osr_r      <= osr_nxt;
    d_r        <= d_nxt;
    r1_r       <= r1_nxt;
    r2_r       <= r2_nxt;
    best_osr_r <= best_osr_nxt;
    best_div_r <= best_div_nxt;
    best_dev_r <= best_dev_nxt;
    out_osr_r  <= out_osr_nxt;
    out_div_r  <= out_div_nxt;
  end

  assign cfg_ready            = 1'b1;
  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_oversample_ratio = out_osr_r;
  assign out_baud_divisor     = out_div_r;

endmodule

>>> src/ubds_div.sv
// ubds_div: restoring serial divider, one quotient bit per cycle
// depends on ubds_pkg
module ubds_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ubds_pkg::div_req_t  req,
  output ubds_pkg::div_rsp_t  rsp
);

  logic [ubds_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [ubds_pkg::CLK_W-1:0] quo_r, quo_nxt;
  logic [ubds_pkg::DVS_W-1:0] dvs_r, dvs_nxt;
  logic [ubds_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [ubds_pkg::DVS_W:0]   trial;
  logic                       fits;

  assign trial = {rem_r, quo_r[ubds_pkg::CLK_W-1]};
  assign fits  = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      cnt_nxt  = ubds_pkg::CNT_W'(ubds_pkg::CLK_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the difference fits DVS_W
      if (fits) begin
        rem_nxt = ubds_pkg::DVS_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[ubds_pkg::DVS_W-1:0];
      end
      quo_nxt = {quo_r[ubds_pkg::CLK_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == ubds_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
